// ----- hdl/titt_pkg.sv -----
// Package for the task interval timer table: widths, request codes,
// transaction payload types and the table entry layout. No dependencies.
package titt_pkg;

    localparam int NUM_TASKS_DEF = 16;
    localparam int REQ_W         = 3;
    localparam int ID_W          = 8;
    localparam int MS_W          = 32;

    localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_EVERY   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ONCE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RESTART = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CANCEL  = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [ID_W-1:0]  task_id;
        logic [MS_W-1:0]  period_ms;
    } t_req_item;

    typedef struct packed {
        logic fired;
        logic id_error;
    } t_rsp_item;

    typedef struct packed {
        logic [MS_W-1:0] stamp_ms;
        logic            oneshot_done;
        logic            task_off;
    } t_entry;

endpackage

// ----- hdl/titt_ifs.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on titt_pkg for the payload types.
interface titt_req_if import titt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_req_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface titt_rsp_if import titt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_rsp_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/titt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module titt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/task_interval_timer_table_core.sv -----
// Task interval timer table: top level. Uses titt_pkg, titt_ifs and titt_ram.
//
//   channel | dir | payload                          | transaction
//   i_req   | in  | req_type, task_id, period_ms     | valid & ready
//   o_rsp   | out | fired, id_error                  | valid & ready
//
// Each request passes S_IDLE, where it is accepted and the table read
// starts, then S_EXEC: compare and write back into the output register.
// The registered RAM read sets this. Reset clears the ms counter and the
// per-entry valid bits; an entry not written since reset reads as zero.
// A new request is taken while a response waits; a stalled response holds the request in S_EXEC.
module task_interval_timer_table_core import titt_pkg::*; #(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    titt_req_if.sink    i_req,
    titt_rsp_if.source  o_rsp
);
    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state               r_state;
    logic [MS_W-1:0]      r_now;
    logic [NUM_TASKS-1:0] r_valid;
    logic                 r_rsp_valid;
    t_rsp_item            r_rsp;

    logic [REQ_W-1:0]     r_req;
    logic [IDX_W-1:0]     r_idx;
    logic [MS_W-1:0]      r_period;
    logic                 r_err;
    logic                 r_ent_vld;

    logic                 accept;
    logic                 go;
    logic                 in_range;
    logic                 task_req;
    logic [IDX_W-1:0]     in_idx;
    t_entry               rd_entry;
    t_entry               cur;
    logic [MS_W-1:0]      elapsed;
    logic                 due;
    t_entry               n_entry;
    logic                 n_we;
    logic                 n_fire;
    logic [MS_W-1:0]      n_now;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    assign in_idx   = i_req.payload.task_id[IDX_W-1:0];
    assign in_range = (i_req.payload.task_id < ID_W'(NUM_TASKS));
    assign task_req = (i_req.payload.req_type == REQ_EVERY)
                   || (i_req.payload.req_type == REQ_ONCE)
                   || (i_req.payload.req_type == REQ_RESTART)
                   || (i_req.payload.req_type == REQ_CANCEL);

    assign go = (r_state == S_EXEC) && (!r_rsp_valid || o_rsp.ready);

    titt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (go && n_we),
        .i_waddr (r_idx),
        .i_wdata (n_entry),
        .i_re    (accept),
        .i_raddr (in_idx),
        .o_rdata (rd_entry)
    );

    assign cur     = r_ent_vld ? rd_entry : '0;
    assign elapsed = r_now - cur.stamp_ms;
    assign due     = (elapsed >= r_period);

    always_comb begin
        n_entry = cur;
        n_we    = 1'b0;
        n_fire  = 1'b0;
        n_now   = r_now;
        case (r_req)
            REQ_TICK: begin
                n_now = r_now + MS_W'(1);
            end
            REQ_EVERY: begin
                if (!r_err && !cur.task_off && due) begin
                    n_entry.stamp_ms = r_now;
                    n_we   = 1'b1;
                    n_fire = 1'b1;
                end
            end
            REQ_ONCE: begin
                if (!r_err && !cur.task_off && !cur.oneshot_done && due) begin
                    n_entry.oneshot_done = 1'b1;
                    n_we   = 1'b1;
                    n_fire = 1'b1;
                end
            end
            REQ_RESTART: begin
                if (!r_err) begin
                    n_entry.stamp_ms     = r_now;
                    n_entry.oneshot_done = 1'b0;
                    n_entry.task_off     = 1'b0;
                    n_we = 1'b1;
                end
            end
            REQ_CANCEL: begin
                if (!r_err) begin
                    n_entry.task_off = 1'b1;
                    n_we = 1'b1;
                end
            end
            default: begin
                n_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_valid     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (r_rsp_valid && o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (go) begin
                        r_state     <= S_IDLE;
                        r_rsp_valid <= 1'b1;
                        r_now       <= n_now;
                        if (n_we) begin
                            r_valid[r_idx] <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= i_req.payload.req_type;
            r_idx     <= in_idx;
            r_period  <= i_req.payload.period_ms;
            r_err     <= task_req && !in_range;
            r_ent_vld <= in_range && r_valid[in_idx];
        end
        if (go) begin
            r_rsp.fired    <= n_fire;
            r_rsp.id_error <= r_err;
        end
    end
endmodule

// ----- verif/titt_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the task interval timer table: watches both channels,
// predicts each response from its request and compares in order.
// Depends on titt_pkg and titt_ifs.
module titt_checker import titt_pkg::*; #(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    titt_req_if   i_req_mon,
    titt_rsp_if   i_rsp_mon,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int MAX_REPORTS = 10;

    logic [MS_W-1:0] clock_ms;
    logic [MS_W-1:0] stamp_tbl [NUM_TASKS];
    logic            shot_done [NUM_TASKS];
    logic            cancelled [NUM_TASKS];
    t_rsp_item       timer_rsp_q [$];

    function automatic t_rsp_item predict_timer(t_req_item rq);
        t_rsp_item       r;
        logic [MS_W-1:0] elapsed;
        int unsigned     idx;
        r   = '0;
        idx = 32'(rq.task_id);
        case (rq.req_type)
            REQ_TICK: begin
                clock_ms = clock_ms + MS_W'(1);
            end
            REQ_EVERY, REQ_ONCE, REQ_RESTART, REQ_CANCEL: begin
                if (idx >= NUM_TASKS) begin
                    r.id_error = 1'b1;
                end else begin
                    elapsed = clock_ms - stamp_tbl[idx];
                    case (rq.req_type)
                        REQ_EVERY: begin
                            if (!cancelled[idx] && elapsed >= rq.period_ms) begin
                                stamp_tbl[idx] = clock_ms;
                                r.fired        = 1'b1;
                            end
                        end
                        REQ_ONCE: begin
                            if (!cancelled[idx] && !shot_done[idx] &&
                                elapsed >= rq.period_ms) begin
                                shot_done[idx] = 1'b1;
                                r.fired        = 1'b1;
                            end
                        end
                        REQ_RESTART: begin
                            stamp_tbl[idx] = clock_ms;
                            shot_done[idx] = 1'b0;
                            cancelled[idx] = 1'b0;
                        end
                        default: begin
                            cancelled[idx] = 1'b1;
                        end
                    endcase
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void note_failure(string msg);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp_item want;
        t_rsp_item got;
        if (!i_rst_n) begin
            clock_ms = '0;
            for (int i = 0; i < NUM_TASKS; i++) begin
                stamp_tbl[i] = '0;
                shot_done[i] = 1'b0;
                cancelled[i] = 1'b0;
            end
            timer_rsp_q.delete();
        end else begin
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got = i_rsp_mon.payload;
                if (timer_rsp_q.size() == 0) begin
                    note_failure($sformatf(
                        "response with no request outstanding: fired=%0b id_error=%0b",
                        got.fired, got.id_error));
                end else begin
                    want = timer_rsp_q.pop_front();
                    if (got.fired !== want.fired || got.id_error !== want.id_error) begin
                        note_failure($sformatf(
                            "mismatch: exp fired=%0b id_error=%0b, got fired=%0b id_error=%0b",
                            want.fired, want.id_error, got.fired, got.id_error));
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                timer_rsp_q.push_back(predict_timer(i_req_mon.payload));
            end
        end
        o_pending = timer_rsp_q.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Top of the task interval timer table testbench: clock, reset, request
// stimulus, response back-pressure and verdict. Uses titt_pkg, titt_ifs,
// titt_checker and task_interval_timer_table_core.
module testbench;
    import titt_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int BLOCKS         = 8;
    localparam int BLOCK_ITEMS    = 250;
    localparam int TAIL_CYCLES    = 10;
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = REQ_CANCEL + REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = {REQ_W{1'b1}};
    localparam logic [ID_W-1:0]  ID_TOP        = {ID_W{1'b1}};
    localparam logic [MS_W-1:0]  MS_TOP        = {MS_W{1'b1}};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic no_gaps;
    int   fail_count;
    int   pending;
    int   idle_cycles;

    titt_req_if req_ch();
    titt_rsp_if rsp_ch();

    task_interval_timer_table_core #(
        .NUM_TASKS (NUM_TASKS_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    titt_checker #(
        .NUM_TASKS (NUM_TASKS_DEF)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_ch),
        .i_rsp_mon    (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic t_req_item mk_req(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
                                         logic [MS_W-1:0] period);
        t_req_item r;
        r.req_type  = kind;
        r.task_id   = id;
        r.period_ms = period;
        return r;
    endfunction

    function automatic t_req_item random_req();
        int              pick;
        int              sel;
        logic [REQ_W-1:0] kind;
        logic [ID_W-1:0]  id;
        logic [MS_W-1:0]  period;
        pick = $urandom_range(0, 99);
        if (pick < 36)      kind = REQ_TICK;
        else if (pick < 58) kind = REQ_EVERY;
        else if (pick < 76) kind = REQ_ONCE;
        else if (pick < 87) kind = REQ_RESTART;
        else if (pick < 95) kind = REQ_CANCEL;
        else                kind = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        if (kind == REQ_TICK || kind > REQ_CANCEL) begin
            return mk_req(kind, ID_W'($urandom()), $urandom());
        end
        if ($urandom_range(0, 9) == 0) begin
            id = ID_W'($urandom_range(NUM_TASKS_DEF, ID_TOP));
        end else begin
            id = ID_W'($urandom_range(0, NUM_TASKS_DEF - 1));
        end
        sel = $urandom_range(0, 9);
        if (sel == 0)      period = $urandom();
        else if (sel == 1) period = '0;
        else               period = $urandom_range(0, 24);
        return mk_req(kind, id, period);
    endfunction

    // Enter at a falling edge; return at the falling edge after acceptance.
    task automatic send_req(t_req_item item);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.payload <= item;
        req_ch.valid   <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Response back-pressure: hold ready low for a random stall before each transaction, except in gap-free blocks.
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge i_clk);
        end
    end

    initial begin
        t_req_item item;
        int        n;
        i_rst_n        = 1'b0;
        no_gaps        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_req(mk_req(REQ_TICK, '0, '0));
        send_req(mk_req(REQ_EVERY, ID_W'(0), '0));
        send_req(mk_req(REQ_EVERY, ID_W'(0), MS_TOP));
        send_req(mk_req(REQ_ONCE, ID_W'(NUM_TASKS_DEF - 1), '0));
        send_req(mk_req(REQ_ONCE, ID_W'(NUM_TASKS_DEF - 1), '0));
        send_req(mk_req(REQ_RESTART, ID_W'(NUM_TASKS_DEF - 1), MS_TOP));
        send_req(mk_req(REQ_ONCE, ID_W'(NUM_TASKS_DEF - 1), '0));
        send_req(mk_req(REQ_CANCEL, ID_W'(3), MS_TOP));
        send_req(mk_req(REQ_EVERY, ID_W'(3), '0));
        send_req(mk_req(REQ_ONCE, ID_W'(3), '0));
        send_req(mk_req(REQ_RESTART, ID_W'(3), '0));
        send_req(mk_req(REQ_EVERY, ID_W'(3), '0));
        send_req(mk_req(REQ_EVERY, ID_W'(NUM_TASKS_DEF), '0));
        send_req(mk_req(REQ_ONCE, ID_TOP, MS_TOP));
        send_req(mk_req(REQ_RESTART, 8'h80, '0));
        send_req(mk_req(REQ_CANCEL, ID_W'(NUM_TASKS_DEF), '0));
        send_req(mk_req(REQ_TICK, ID_TOP, MS_TOP));
        for (int k = REQ_UNUSED_LO; k <= REQ_UNUSED_HI; k++) begin
            send_req(mk_req(REQ_W'(k), ID_TOP, MS_TOP));
        end
        repeat (3) send_req(mk_req(REQ_TICK, '0, '0));
        send_req(mk_req(REQ_EVERY, ID_W'(1), 32'd4));
        send_req(mk_req(REQ_EVERY, ID_W'(1), 32'd1));
        send_req(mk_req(REQ_ONCE, ID_W'(2), 32'd5));
        wait_drained();

        for (int blk = 0; blk < BLOCKS; blk++) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if (blk == BLOCKS / 2) wait_drained();
            n = 0;
            while (n < BLOCK_ITEMS) begin
                item = random_req();
                send_req(item);
                if (item.req_type <= REQ_CANCEL) n++;
            end
        end
        req_ch.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
